### src/idq_pkg.sv
// Shared types, step codes and format conversions for the int4/int8 dequant dot block.
package idq_pkg;

  // Step codes of the shared floating-point unit sequence
  typedef logic [2:0] step_t;
  localparam step_t STEP_V0  = 3'd0;
  localparam step_t STEP_V1  = 3'd1;
  localparam step_t STEP_W0  = 3'd2;
  localparam step_t STEP_W1  = 3'd3;
  localparam step_t STEP_P0  = 3'd4;
  localparam step_t STEP_P1  = 3'd5;
  localparam step_t STEP_T   = 3'd6;
  localparam step_t STEP_ACC = 3'd7;

  // FPU operation select
  typedef enum logic {
    FOP_MUL = 1'b0,
    FOP_ADD = 1'b1
  } fop_e;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam logic [31:0] F32_QNAN  = 32'h7FC0_0000;
  localparam logic [31:0] F32_PZERO = 32'h0000_0000;
  localparam logic [3:0]  NIB_MASK  = 4'hF;

  // Widen an fp16 pattern exactly to fp32
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] pos;
    logic [22:0] fr;
    logic [31:0] r;
    e   = h[14:10];
    m   = h[9:0];
    pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) pos = 4'(i);
    end
    fr = 23'({m, 13'b0} << (4'd10 - pos));
    if (e == 5'd0) begin
      if (m == 10'd0) r = {h[15], 31'b0};
      else r = {h[15], 8'(8'd103 + 8'(pos)), fr};
    end else if (e == 5'h1F) begin
      r = {h[15], 8'hFF, m, 13'b0};
    end else begin
      r = {h[15], 8'(8'(e) + 8'd112), m, 13'b0};
    end
    return r;
  endfunction

  // Convert a signed 8-bit integer exactly to fp32
  function automatic logic [31:0] int8_to_f32(input logic signed [7:0] v);
    logic [7:0] mag;
    logic [2:0] pos;
    logic [31:0] r;
    mag = v[7] ? 8'(-v) : 8'(v);
    pos = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) pos = 3'(i);
    end
    if (mag == 8'd0) r = F32_PZERO;
    else r = {v[7], 8'(8'd127 + 8'(pos)), 23'({mag, 15'b0} << (4'd8 - 4'(pos)))};
    return r;
  endfunction

endpackage

### src/idq_fpu.sv
// Shared fp32 multiply/add unit, round to nearest even, full subnormal support.
module idq_fpu (
  input  idq_pkg::fop_e op_i,
  input  logic [31:0]   a_i,
  input  logic [31:0]   b_i,
  output logic [31:0]   y_o
);

  // Normalize, round and pack; value = m / 2^47 * 2^(ex - 127)
  function automatic logic [31:0] rnd_pack(input logic sgn, input logic signed [11:0] ex,
                                            input logic [47:0] m);
    logic [5:0] lz;
    logic [47:0] mn;
    logic signed [11:0] e;
    logic [11:0] sh;
    logic st;
    logic [7:0] ef;
    logic rup;
    logic [30:0] r;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) lz = 6'(47 - i);
    end
    mn = m << lz;
    e  = ex - 12'(lz);
    st = 1'b0;
    ef = e[7:0];
    if (e <= 0) begin
      sh = 12'(12'sd1 - e);
      ef = 8'd0;
      if (sh >= 12'd48) begin
        st = |mn;
        mn = '0;
      end else begin
        st = |(mn & ~(48'hFFFF_FFFF_FFFF << sh[5:0]));
        mn = mn >> sh[5:0];
      end
    end
    rup = mn[23] & ((|mn[22:0]) | st | mn[24]);
    r   = {ef, mn[46:24]} + 31'(rup);
    if (m == 48'd0) return {sgn, 31'b0};
    if (e >= 12'sd255) return {sgn, 8'hFF, 23'b0};
    return {sgn, r};
  endfunction

  logic        sa, sb;
  logic [7:0]  ea, eb, eae, ebe;
  logic [23:0] ma, mb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [47:0] prod;
  logic [31:0] mul_y, add_y;
  // adder path
  logic        swp, sx, sy;
  logic [7:0]  ex, ey, d;
  logic [47:0] xm, ym, ys, sum;
  logic        st;

  // Unpack operands
  always_comb begin
    sa     = a_i[31];
    sb     = b_i[31];
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    eae    = (ea == 8'd0) ? 8'd1 : ea;
    ebe    = (eb == 8'd0) ? 8'd1 : eb;
    ma     = {ea != 8'd0, a_i[22:0]};
    mb     = {eb != 8'd0, b_i[22:0]};
    nan_a  = (ea == 8'hFF) && (a_i[22:0] != 23'd0);
    nan_b  = (eb == 8'hFF) && (b_i[22:0] != 23'd0);
    inf_a  = (ea == 8'hFF) && (a_i[22:0] == 23'd0);
    inf_b  = (eb == 8'hFF) && (b_i[22:0] == 23'd0);
    zero_a = a_i[30:0] == 31'd0;
    zero_b = b_i[30:0] == 31'd0;
  end

  // Multiply path
  always_comb begin
    prod = ma * mb;
    if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
      mul_y = idq_pkg::F32_QNAN;
    end else if (inf_a || inf_b) begin
      mul_y = {sa ^ sb, 8'hFF, 23'b0};
    end else begin
      mul_y = rnd_pack(sa ^ sb, 12'(eae) + 12'(ebe) - 12'sd126, prod);
    end
  end

  // Add path: align smaller magnitude to larger, add or subtract, round
  always_comb begin
    swp = b_i[30:0] > a_i[30:0];
    sx  = swp ? sb : sa;
    sy  = swp ? sa : sb;
    ex  = swp ? ebe : eae;
    ey  = swp ? eae : ebe;
    xm  = {1'b0, (swp ? mb : ma), 23'b0};
    ym  = {1'b0, (swp ? ma : mb), 23'b0};
    d   = ex - ey;
    if (d >= 8'd48) begin
      st = |ym;
      ys = '0;
    end else begin
      st = |(ym & ~(48'hFFFF_FFFF_FFFF << d[5:0]));
      ys = ym >> d[5:0];
    end
    ys  = ys | 48'(st);
    sum = (sx == sy) ? xm + ys : xm - ys;
    if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
      add_y = idq_pkg::F32_QNAN;
    end else if (inf_a) begin
      add_y = {sa, 8'hFF, 23'b0};
    end else if (inf_b) begin
      add_y = {sb, 8'hFF, 23'b0};
    end else begin
      add_y = rnd_pack((sum == 48'd0) ? (sx & sy) : sx, 12'(ex) + 12'sd1, sum);
    end
  end

  assign y_o = (op_i == idq_pkg::FOP_ADD) ? add_y : mul_y;

endmodule

### src/int4_int8_dequant_dot_accumulate.sv
// Top level: sequencer, operand registers and running sum around the shared fp32 unit.
// Each accepted item runs eight steps through one shared fp32 multiply/add unit, one step
// per cycle unless the accumulate step stalls: four scale products, two weight-activation
// products, the pair sum and the accumulate. s_axis_tready_o is low while the steps run and
// returns high in the cycle after the accumulate, so no new item is taken before the last
// is through; the eight serial steps through the one unit set the item rate. The accumulate
// step waits only when an item with tlast must emit while the previous result is still held
// in the output register and not taken. The running sum restarts at +0.0 on tuser, is
// emitted after adding on tlast and is kept afterwards; NaN sums come out as 0x7FC00000.
module int4_int8_dequant_dot_accumulate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] weight_byte, [23:8] weight_scale_bits, [31:24] act_first,
  // [39:32] act_second, [55:40] act_scale_bits
  input  logic [55:0] s_axis_tdata_i,
  // [0] start_sum
  input  logic        s_axis_tuser_i,
  // end_sum
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] sum_bits
  output logic [31:0] m_axis_tdata_o
);

  idq_pkg::state_e state_q, state_d;
  idq_pkg::step_t  step_q, step_d;
  idq_pkg::fop_e   fop;
  logic [31:0] act0_q, act1_q, q0_q, q1_q, sa_q, sw_q;
  logic [31:0] r0_q, r1_q, r2_q, r3_q;
  logic [31:0] sum_q, sum_d;
  logic        start_q, end_q;
  logic [31:0] op_a, op_b, fy;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_q;
  logic        s_acc, stall, emit;
  logic [7:0]  wb;

  assign s_axis_tready_o = state_q == idq_pkg::ST_IDLE;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign wb    = s_axis_tdata_i[7:0];
  assign stall = (step_q == idq_pkg::STEP_ACC) && end_q && out_valid_q && !m_axis_tready_i;
  assign emit  = (state_q == idq_pkg::ST_RUN) && (step_q == idq_pkg::STEP_ACC) && end_q
                 && !stall;

  // Select operands for the current step
  always_comb begin
    fop  = idq_pkg::FOP_MUL;
    op_a = r0_q;
    op_b = r1_q;
    case (step_q)
      idq_pkg::STEP_V0: begin op_a = act0_q; op_b = sa_q; end
      idq_pkg::STEP_V1: begin op_a = act1_q; op_b = sa_q; end
      idq_pkg::STEP_W0: begin op_a = q0_q;   op_b = sw_q; end
      idq_pkg::STEP_W1: begin op_a = q1_q;   op_b = sw_q; end
      idq_pkg::STEP_P0: begin op_a = r0_q;   op_b = r2_q; end
      idq_pkg::STEP_P1: begin op_a = r1_q;   op_b = r3_q; end
      idq_pkg::STEP_T: begin
        fop = idq_pkg::FOP_ADD;
      end
      idq_pkg::STEP_ACC: begin
        fop  = idq_pkg::FOP_ADD;
        op_a = start_q ? idq_pkg::F32_PZERO : sum_q;
        op_b = r0_q;
      end
      default: ;
    endcase
  end

  idq_fpu u_fpu (
    .op_i (fop),
    .a_i  (op_a),
    .b_i  (op_b),
    .y_o  (fy)
  );

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    sum_d   = sum_q;
    case (state_q)
      idq_pkg::ST_IDLE: begin
        if (s_acc) begin
          state_d = idq_pkg::ST_RUN;
          step_d  = idq_pkg::STEP_V0;
        end
      end
      idq_pkg::ST_RUN: begin
        if (step_q == idq_pkg::STEP_ACC) begin
          if (!stall) begin
            sum_d   = fy;
            state_d = idq_pkg::ST_IDLE;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      default: state_d = idq_pkg::ST_IDLE;
    endcase
    out_valid_d = (out_valid_q && !m_axis_tready_i) || emit;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idq_pkg::ST_IDLE;
      step_q      <= idq_pkg::STEP_V0;
      sum_q       <= idq_pkg::F32_PZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture item operands, hold step results, load the output register
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      q0_q    <= idq_pkg::int8_to_f32({{4{wb[3]}}, wb[3:0] & idq_pkg::NIB_MASK});
      q1_q    <= idq_pkg::int8_to_f32({{4{wb[7]}}, wb[7:4] & idq_pkg::NIB_MASK});
      sw_q    <= idq_pkg::half_to_f32(s_axis_tdata_i[23:8]);
      act0_q  <= idq_pkg::int8_to_f32(s_axis_tdata_i[31:24]);
      act1_q  <= idq_pkg::int8_to_f32(s_axis_tdata_i[39:32]);
      sa_q    <= idq_pkg::half_to_f32(s_axis_tdata_i[55:40]);
      start_q <= s_axis_tuser_i;
      end_q   <= s_axis_tlast_i;
    end
    if (state_q == idq_pkg::ST_RUN) begin
      case (step_q)
        idq_pkg::STEP_V0, idq_pkg::STEP_P0, idq_pkg::STEP_T: r0_q <= fy;
        idq_pkg::STEP_V1, idq_pkg::STEP_P1: r1_q <= fy;
        idq_pkg::STEP_W0: r2_q <= fy;
        idq_pkg::STEP_W1: r3_q <= fy;
        default: ;
      endcase
    end
    if (emit) begin
      out_q <= ((fy[30:23] == 8'hFF) && (fy[22:0] != 23'd0)) ? idq_pkg::F32_QNAN : fy;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

### src/idq_chk.sv
// Port-level checker for the dequant dot block, bound to the top level.
module idq_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output item dropped or changed while stalled");

  // Drop ready after an accepted item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is still in work");

  // A result must not rise too early after its item
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> ##1 !$rose(m_axis_tvalid_o))
    else $error("result appeared too early");

  // Emitted NaN is canonical
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[30:23] == 8'hFF) && (m_axis_tdata_o[22:0] != 23'd0)
    |-> m_axis_tdata_o == 32'h7FC0_0000)
    else $error("non-canonical NaN emitted");

endmodule

bind int4_int8_dequant_dot_accumulate idq_chk u_idq_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
